/* rtl/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, codes and character classes for the Smalltalk token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int COL_BITS_DEF    = 16;
  localparam int OFFSET_BITS_DEF = 24;

  // bit 8 marks a byte as present in the lookahead
  typedef logic [8:0] lb_t;

  typedef struct packed {
    logic [7:0] c;
    lb_t        a;
    lb_t        b;
    lb_t        d;
    logic       fin;   // end of source: finish request
    logic       fl;    // part of a flush run
  } job_t;

  typedef enum logic [23:0] {
    M_IDLE    = 24'h000001,
    M_COMMENT = 24'h000002,
    M_CSKIP   = 24'h000004,
    M_STR     = 24'h000008,
    M_STRSKIP = 24'h000010,
    M_SYMSTR  = 24'h000020,
    M_SYMSKIP = 24'h000040,
    M_SYMQ    = 24'h000080,
    M_SYMID   = 24'h000100,
    M_SYMBIN  = 24'h000200,
    M_HPAREN  = 24'h000400,
    M_HBRACK  = 24'h000800,
    M_CHARLIT = 24'h001000,
    M_IDENT   = 24'h002000,
    M_KWCOLON = 24'h004000,
    M_ASSIGN2 = 24'h008000,
    M_BINARY  = 24'h010000,
    M_INT     = 24'h020000,
    M_R       = 24'h040000,
    M_RADIX   = 24'h080000,
    M_DOT     = 24'h100000,
    M_FRAC    = 24'h200000,
    M_EXPL    = 24'h400000,
    M_EXPD    = 24'h800000
  } mode_t;

  typedef enum logic [2:0] {
    ND_BYTE, ND_R, ND_DOT, ND_EXP, ND_CLOSE
  } nd_t;

  localparam logic [4:0] K_INT       = 5'd0;
  localparam logic [4:0] K_FLOAT     = 5'd1;
  localparam logic [4:0] K_STRING    = 5'd2;
  localparam logic [4:0] K_SYMBOL    = 5'd3;
  localparam logic [4:0] K_SYMARRAY  = 5'd4;
  localparam logic [4:0] K_BYTEARRAY = 5'd5;
  localparam logic [4:0] K_CHAR      = 5'd6;
  localparam logic [4:0] K_IDENT     = 5'd7;
  localparam logic [4:0] K_KEYWORD   = 5'd8;
  localparam logic [4:0] K_BINARY    = 5'd9;
  localparam logic [4:0] K_ASSIGN    = 5'd10;
  localparam logic [4:0] K_COLON     = 5'd11;
  localparam logic [4:0] K_CARET     = 5'd12;
  localparam logic [4:0] K_DOT       = 5'd13;
  localparam logic [4:0] K_SEMI      = 5'd14;
  localparam logic [4:0] K_LPAREN    = 5'd15;
  localparam logic [4:0] K_RPAREN    = 5'd16;
  localparam logic [4:0] K_LBRACK    = 5'd17;
  localparam logic [4:0] K_RBRACK    = 5'd18;
  localparam logic [4:0] K_LBRACE    = 5'd19;
  localparam logic [4:0] K_RBRACE    = 5'd20;
  localparam logic [4:0] K_BAR       = 5'd21;
  localparam logic [4:0] K_EOF       = 5'd22;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_COMMENT = 2'd1;
  localparam logic [1:0] E_STRING  = 2'd2;
  localparam logic [1:0] E_CHAR    = 2'd3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_R     = 8'h72;

  function automatic logic eqc(lb_t x, logic [7:0] ch);
    return x[8] && (x[7:0] == ch);
  endfunction

  function automatic logic is_digit(lb_t x);
    return x[8] && (x[7:0] >= 8'h30) && (x[7:0] <= 8'h39);
  endfunction

  function automatic logic is_alpha(lb_t x);
    return x[8] && (((x[7:0] >= 8'h41) && (x[7:0] <= 8'h5A)) ||
                    ((x[7:0] >= 8'h61) && (x[7:0] <= 8'h7A)));
  endfunction

  function automatic logic id_start(lb_t x);
    return is_alpha(x) || eqc(x, 8'h5F);
  endfunction

  function automatic logic id_cont(lb_t x);
    return id_start(x) || is_digit(x);
  endfunction

  function automatic logic is_alnum(lb_t x);
    return is_alpha(x) || is_digit(x);
  endfunction

  function automatic logic is_exp(lb_t x);
    return eqc(x, 8'h65) || eqc(x, 8'h45) || eqc(x, 8'h64) || eqc(x, 8'h44);
  endfunction

  function automatic logic is_space(lb_t x);
    return eqc(x, 8'h20) || eqc(x, 8'h09) || eqc(x, 8'h0D) || eqc(x, CH_NL) ||
           eqc(x, 8'h0C) || eqc(x, 8'h0B);
  endfunction

  function automatic logic is_binary(lb_t x);
    return eqc(x, CH_PLUS) || eqc(x, CH_MINUS) || eqc(x, 8'h2A) || eqc(x, 8'h2F) ||
           eqc(x, 8'h7E) || eqc(x, 8'h3C) || eqc(x, 8'h3E) || eqc(x, CH_EQ) ||
           eqc(x, 8'h26) || eqc(x, CH_BAR) || eqc(x, 8'h40) || eqc(x, 8'h25) ||
           eqc(x, 8'h2C) || eqc(x, 8'h3F) || eqc(x, 8'h21) || eqc(x, 8'h5C);
  endfunction

  // {found, kind}
  function automatic logic [5:0] punct(logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      8'h5E:   r = {1'b1, K_CARET};
      8'h2E:   r = {1'b1, K_DOT};
      8'h3B:   r = {1'b1, K_SEMI};
      8'h28:   r = {1'b1, K_LPAREN};
      8'h29:   r = {1'b1, K_RPAREN};
      8'h5B:   r = {1'b1, K_LBRACK};
      8'h5D:   r = {1'b1, K_RBRACK};
      8'h7B:   r = {1'b1, K_LBRACE};
      8'h7D:   r = {1'b1, K_RBRACE};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic nd_t nd_sel(lb_t a, lb_t b, lb_t d, logic rok);
    nd_t r;
    if (is_digit(a)) r = ND_BYTE;
    else if (rok && eqc(a, CH_R)) r = ND_R;
    else if (rok && eqc(a, CH_DOT) && is_digit(b)) r = ND_DOT;
    else if (is_exp(a) && (is_digit(b) ||
             ((eqc(b, CH_PLUS) || eqc(b, CH_MINUS)) && is_digit(d)))) r = ND_EXP;
    else r = ND_CLOSE;
    return r;
  endfunction

endpackage

/* rtl/stl_front.sv */
// ----------------------------------------------------------------------------
// stl_front
// Three-byte lookahead window; issues scan requests and the end-of-source
// flush sequence into the request queue.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       last_byte,
  output logic       push,
  output job_t       job,
  input  logic       q_full
);

  logic [7:0] win [3];
  logic [1:0] wcnt;
  logic [7:0] fbuf [4];
  logic [2:0] fn;
  logic [2:0] fi;
  logic       flushing;
  logic       acc;
  logic [2:0] fa, fb, fd;

  assign in_stall = flushing || q_full;
  assign acc      = in_valid && !in_stall;
  assign fa       = fi + 3'd1;
  assign fb       = fi + 3'd2;
  assign fd       = fi + 3'd3;

  always_comb begin
    job  = '0;
    push = 1'b0;
    if (flushing) begin
      push    = !q_full;
      job.fl  = 1'b1;
      job.fin = (fi == fn);
      job.c   = fbuf[fi[1:0]];
      job.a   = {(fa < fn), fbuf[fa[1:0]]};
      job.b   = {(fb < fn), fbuf[fb[1:0]]};
      job.d   = {(fd < fn), fbuf[fd[1:0]]};
    end else if (acc && !last_byte && (wcnt == 2'd3)) begin
      push  = 1'b1;
      job.c = win[0];
      job.a = {1'b1, win[1]};
      job.b = {1'b1, win[2]};
      job.d = {1'b1, char_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt     <= 2'd0;
      flushing <= 1'b0;
      fi       <= 3'd0;
      fn       <= 3'd0;
    end else if (flushing) begin
      if (!q_full) begin
        fi <= fi + 3'd1;
        if (fi == fn) flushing <= 1'b0;
      end
    end else if (acc) begin
      if (last_byte) begin
        fbuf[0]        <= (wcnt == 2'd0) ? char_in : win[0];
        fbuf[1]        <= (wcnt == 2'd1) ? char_in : win[1];
        fbuf[2]        <= (wcnt == 2'd2) ? char_in : win[2];
        fbuf[3]        <= char_in;
        fn             <= {1'b0, wcnt} + 3'd1;
        fi             <= 3'd0;
        flushing       <= 1'b1;
        wcnt           <= 2'd0;
      end else if (wcnt == 2'd3) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= char_in;
      end else begin
        win[wcnt] <= char_in;
        wcnt      <= wcnt + 2'd1;
      end
    end
  end

endmodule

/* rtl/stl_queue.sv */
// ----------------------------------------------------------------------------
// stl_queue
// Two-entry request queue between the window front and the scanner.
// ----------------------------------------------------------------------------
module stl_queue import stl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic empty,
  output logic full
);

  job_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign empty = (cnt == 2'd0);
  assign full  = (cnt == 2'd2);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/stl_back.sv */
// ----------------------------------------------------------------------------
// stl_back
// Scanner: runs the lexer mode machine on one request per cycle while the
// output is not stalled, and holds the result in an output register.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; #(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COL_BITS    = COL_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  job_t                   job,
  input  logic                   q_empty,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   has_byte,
  output logic [7:0]             text_byte,
  output logic                   token_end,
  output logic [4:0]             kind,
  output logic [LINE_BITS-1:0]   tok_line,
  output logic [COL_BITS-1:0]    tok_col,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [1:0]             error_code,
  output logic                   last_of_run
);

  mode_t                  mode, mode_next;
  logic                   flt, flt_next;
  logic [LINE_BITS-1:0]   line, line_next, ts_line, ts_line_next;
  logic [COL_BITS-1:0]    col, col_next, ts_col, ts_col_next;
  logic [OFFSET_BITS-1:0] off, off_next, ts_off, ts_off_next;
  logic                   err, err_next;

  lb_t        c, a, b, d;
  logic       tb, tc, tc_has, raise, adv, do_nd, rok;
  logic [4:0] tc_kind;
  nd_t        nd;
  logic [5:0] pk;
  logic [1:0] e_code;
  logic [LINE_BITS-1:0]   e_line;
  logic [COL_BITS-1:0]    e_col;
  logic [OFFSET_BITS-1:0] e_off;

  logic                   r_v, r_has, r_end, r_last;
  logic [7:0]             r_byte;
  logic [4:0]             r_kind;
  logic [1:0]             r_err;
  logic [LINE_BITS-1:0]   r_line;
  logic [COL_BITS-1:0]    r_col;
  logic [OFFSET_BITS-1:0] r_off;

  assign pop = !q_empty && (!out_valid || !out_stall);
  assign c   = {1'b1, job.c};
  assign a   = job.a;
  assign b   = job.b;
  assign d   = job.d;
  assign pk  = punct(job.c);

  always_comb begin
    mode_next    = mode;
    flt_next     = flt;
    line_next    = line;
    col_next     = col;
    off_next     = off;
    ts_line_next = ts_line;
    ts_col_next  = ts_col;
    ts_off_next  = ts_off;
    err_next     = err;
    tb = 1'b0; tc = 1'b0; tc_has = 1'b1; tc_kind = K_INT;
    raise = 1'b0; adv = 1'b0; do_nd = 1'b0; rok = 1'b1;
    e_code = E_NONE; e_line = line; e_col = col; e_off = off;
    nd = nd_sel(a, b, d, rok);
    r_v = 1'b0; r_has = 1'b0; r_byte = 8'd0; r_end = 1'b0; r_kind = K_INT;
    r_err = E_NONE; r_line = ts_line; r_col = ts_col; r_off = ts_off;
    r_last = 1'b1;

    if (job.fin) begin
      if (!err) begin
        r_v = 1'b1;
        if (mode == M_COMMENT || mode == M_CSKIP) begin
          r_err = E_COMMENT;
        end else if (mode == M_STR || mode == M_STRSKIP) begin
          r_err = E_STRING;
        end else if (mode == M_SYMSTR || mode == M_SYMSKIP || mode == M_SYMQ) begin
          r_err = E_STRING;
          r_col = (&ts_col) ? ts_col : ts_col + COL_BITS'(1);
          r_off = (&ts_off) ? ts_off : ts_off + OFFSET_BITS'(1);
        end else begin
          r_end  = 1'b1;
          r_kind = K_EOF;
          r_line = line;
          r_col  = col;
          r_off  = off;
        end
      end
      mode_next    = M_IDLE;
      flt_next     = 1'b0;
      line_next    = LINE_BITS'(1);
      col_next     = COL_BITS'(1);
      off_next     = '0;
      ts_line_next = '0;
      ts_col_next  = '0;
      ts_off_next  = '0;
      err_next     = 1'b0;
    end else if (!err) begin
      adv = 1'b1;
      unique case (mode)
        M_IDLE: begin
          if (!is_space(c)) begin
            ts_line_next = line;
            ts_col_next  = col;
            ts_off_next  = off;
            if (eqc(c, CH_DQ)) begin
              mode_next = M_COMMENT;
            end else if (is_digit(c) || (eqc(c, CH_MINUS) && is_digit(a))) begin
              flt_next  = 1'b0;
              mode_next = M_INT;
              do_nd     = 1'b1;
            end else if (eqc(c, CH_SQ)) begin
              mode_next = M_STR;
            end else if (eqc(c, CH_HASH)) begin
              if (eqc(a, CH_LPAR)) begin
                tb = 1'b1; mode_next = M_HPAREN;
              end else if (eqc(a, CH_LBRK)) begin
                tb = 1'b1; mode_next = M_HBRACK;
              end else if (eqc(a, CH_SQ)) begin
                mode_next = M_SYMQ;
              end else if (id_start(a)) begin
                mode_next = M_SYMID;
              end else if (is_binary(a)) begin
                mode_next = M_SYMBIN;
              end else begin
                tc = 1'b1; tc_has = 1'b0; tc_kind = K_SYMBOL;
              end
            end else if (eqc(c, CH_DOLL)) begin
              if (!a[8]) begin
                tc = 1'b1; tc_has = 1'b0; tc_kind = K_CHAR;
              end else begin
                mode_next = M_CHARLIT;
              end
            end else if (id_start(c)) begin
              mode_next = M_IDENT;
              if (id_cont(a)) begin
                tb = 1'b1;
              end else if (eqc(a, CH_COLON) && !eqc(b, CH_EQ)) begin
                tb = 1'b1; mode_next = M_KWCOLON;
              end else begin
                tc = 1'b1; tc_kind = K_IDENT;
              end
            end else if (eqc(c, CH_COLON)) begin
              if (eqc(a, CH_EQ)) begin
                tb = 1'b1; mode_next = M_ASSIGN2;
              end else begin
                tc = 1'b1; tc_kind = K_COLON;
              end
            end else if (pk[5]) begin
              tc = 1'b1; tc_kind = pk[4:0];
            end else if (eqc(c, CH_BAR) && !is_binary(a)) begin
              tc = 1'b1; tc_kind = K_BAR;
            end else if (is_binary(c)) begin
              mode_next = M_BINARY;
              if (is_binary(a)) tb = 1'b1;
              else begin
                tc = 1'b1; tc_kind = K_BINARY;
              end
            end else begin
              raise  = 1'b1;
              adv    = 1'b0;
              e_code = E_CHAR;
            end
          end
        end
        M_COMMENT: begin
          if (eqc(c, CH_DQ)) mode_next = eqc(a, CH_DQ) ? M_CSKIP : M_IDLE;
        end
        M_CSKIP: mode_next = M_COMMENT;
        M_STR, M_SYMSTR: begin
          if (eqc(c, CH_SQ)) begin
            if (eqc(a, CH_SQ)) begin
              tb        = 1'b1;
              mode_next = (mode == M_STR) ? M_STRSKIP : M_SYMSKIP;
            end else begin
              tc = 1'b1; tc_has = 1'b0;
              tc_kind = (mode == M_STR) ? K_STRING : K_SYMBOL;
            end
          end else begin
            tb = 1'b1;
          end
        end
        M_STRSKIP: mode_next = M_STR;
        M_SYMSKIP, M_SYMQ: mode_next = M_SYMSTR;
        M_SYMID: begin
          if (id_cont(a) || eqc(a, CH_COLON)) tb = 1'b1;
          else begin
            tc = 1'b1; tc_kind = K_SYMBOL;
          end
        end
        M_SYMBIN: begin
          if (is_binary(a)) tb = 1'b1;
          else begin
            tc = 1'b1; tc_kind = K_SYMBOL;
          end
        end
        M_BINARY: begin
          if (is_binary(a)) tb = 1'b1;
          else begin
            tc = 1'b1; tc_kind = K_BINARY;
          end
        end
        M_HPAREN: begin
          tc = 1'b1; tc_kind = K_SYMARRAY;
        end
        M_HBRACK: begin
          tc = 1'b1; tc_kind = K_BYTEARRAY;
        end
        M_CHARLIT: begin
          tc = 1'b1; tc_kind = K_CHAR;
        end
        M_ASSIGN2: begin
          tc = 1'b1; tc_kind = K_ASSIGN;
        end
        M_KWCOLON: begin
          tc = 1'b1; tc_kind = K_KEYWORD;
        end
        M_IDENT: begin
          if (id_cont(a)) tb = 1'b1;
          else if (eqc(a, CH_COLON) && !eqc(b, CH_EQ)) begin
            tb = 1'b1; mode_next = M_KWCOLON;
          end else begin
            tc = 1'b1; tc_kind = K_IDENT;
          end
        end
        M_INT: do_nd = 1'b1;
        M_FRAC: begin
          do_nd = 1'b1;
          rok   = 1'b0;
          nd    = nd_sel(a, b, d, rok);
        end
        M_R: begin
          if (eqc(a, CH_MINUS) || is_alnum(a)) begin
            tb = 1'b1; mode_next = M_RADIX;
          end else begin
            tc = 1'b1; tc_kind = K_INT;
          end
        end
        M_RADIX: begin
          if (is_alnum(a)) tb = 1'b1;
          else begin
            tc = 1'b1; tc_kind = K_INT;
          end
        end
        M_DOT: begin
          tb = 1'b1; flt_next = 1'b1; mode_next = M_FRAC;
        end
        M_EXPL: begin
          tb = 1'b1; flt_next = 1'b1; mode_next = M_EXPD;
        end
        M_EXPD: begin
          if (is_digit(a)) tb = 1'b1;
          else begin
            tc = 1'b1; tc_kind = K_FLOAT;
          end
        end
        default: mode_next = M_IDLE;
      endcase

      if (do_nd) begin
        unique case (nd)
          ND_BYTE:  tb = 1'b1;
          ND_R:     begin tb = 1'b1; mode_next = M_R;    end
          ND_DOT:   begin tb = 1'b1; mode_next = M_DOT;  end
          ND_EXP:   begin tb = 1'b1; mode_next = M_EXPL; end
          default:  begin
            tc = 1'b1; tc_kind = flt_next ? K_FLOAT : K_INT;
          end
        endcase
      end

      if (tc) mode_next = M_IDLE;

      if (adv) begin
        off_next = (&off) ? off : off + OFFSET_BITS'(1);
        if (eqc(c, CH_NL)) begin
          line_next = (&line) ? line : line + LINE_BITS'(1);
          col_next  = COL_BITS'(1);
        end else begin
          col_next = (&col) ? col : col + COL_BITS'(1);
        end
      end

      r_line = ts_line_next;
      r_col  = ts_col_next;
      r_off  = ts_off_next;
      if (raise) begin
        r_v       = 1'b1;
        r_err     = e_code;
        r_line    = e_line;
        r_col     = e_col;
        r_off     = e_off;
        err_next  = 1'b1;
        mode_next = M_IDLE;
      end else if (tc) begin
        r_v    = 1'b1;
        r_end  = 1'b1;
        r_kind = tc_kind;
        r_has  = tc_has;
        r_byte = tc_has ? job.c : 8'd0;
      end else if (tb) begin
        r_v    = 1'b1;
        r_has  = 1'b1;
        r_byte = job.c;
      end
      r_last = !job.fl || raise;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      flt     <= 1'b0;
      line    <= LINE_BITS'(1);
      col     <= COL_BITS'(1);
      off     <= '0;
      ts_line <= '0;
      ts_col  <= '0;
      ts_off  <= '0;
      err     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode    <= mode_next;
        flt     <= flt_next;
        line    <= line_next;
        col     <= col_next;
        off     <= off_next;
        ts_line <= ts_line_next;
        ts_col  <= ts_col_next;
        ts_off  <= ts_off_next;
        err     <= err_next;
        out_valid <= r_v;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && r_v) begin
      has_byte     <= r_has;
      text_byte    <= r_byte;
      token_end    <= r_end;
      kind         <= r_kind;
      tok_line     <= r_line;
      tok_col      <= r_col;
      start_offset <= r_off;
      error_code   <= r_err;
      last_of_run  <= r_last;
    end
  end

endmodule

/* rtl/smalltalk_token_lexer.sv */
// ----------------------------------------------------------------------------
// smalltalk_token_lexer
// Results: a byte's request is queued when the byte completing its three-byte
// lookahead is accepted, and its result is registered when the scanner pops
// the request, which output stalls can delay. Throughput: one byte per cycle
// while the queue has room; the last byte of a source holds the input while
// the window is flushed and the end request is issued, one scan per cycle.
// Reset: synchronous; window empty, counters at line 1 column 1 offset 0.
// ----------------------------------------------------------------------------
module smalltalk_token_lexer import stl_pkg::*; #(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COL_BITS    = COL_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             char_in,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   has_byte,
  output logic [7:0]             text_byte,
  output logic                   token_end,
  output logic [4:0]             kind,
  output logic [LINE_BITS-1:0]   tok_line,
  output logic [COL_BITS-1:0]    tok_col,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [1:0]             error_code,
  output logic                   last_of_run
);

  logic push, pop, q_full, q_empty;
  job_t job_in, job_out;

  stl_front u_front (
    .clk, .rst, .in_valid, .in_stall, .char_in, .last_byte,
    .push, .job(job_in), .q_full
  );

  stl_queue u_queue (
    .clk, .rst, .push, .din(job_in), .pop, .dout(job_out),
    .empty(q_empty), .full(q_full)
  );

  stl_back #(
    .LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS), .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk, .rst, .job(job_out), .q_empty, .pop, .out_valid, .out_stall,
    .has_byte, .text_byte, .token_end, .kind, .tok_line, .tok_col,
    .start_offset, .error_code, .last_of_run
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push || pop)
    else $error("request pushed into full queue");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != E_NONE |-> !token_end && !has_byte && last_of_run)
    else $error("error result carries token data");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte && !token_end |-> error_code != E_NONE)
    else $error("empty result emitted");

endmodule
